// ===== design/fhc_pkg.sv =====
// Shared types, constants and helpers for the flow hit counter table.
// Used by every module of the block; no dependencies of its own.
package fhc_pkg;

  localparam int BUCKETS  = 256;
  localparam int WAYS     = 4;
  localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

  localparam logic MODE_COUNT  = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  typedef enum logic [2:0] {
    ST_COUNTED   = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } fhc_status_t;

  typedef enum logic {
    S_IDLE,
    S_LOOKUP
  } fhc_state_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] address;
    logic [15:0] port;
    logic [31:0] count;
  } fhc_entry_t;

  typedef fhc_entry_t [WAYS-1:0] fhc_row_t;

  typedef struct packed {
    logic [31:0] hit_count;
    fhc_status_t status;
  } fhc_result_t;

  // Low address byte modulo BUCKETS; BUCKETS is a power of two, so keep the low bits.
  function automatic logic [BUCKET_W-1:0] bucket_of(logic [7:0] a);
    logic [8:0] rem;
    rem = {1'b0, a} % 9'(BUCKETS);
    return rem[BUCKET_W-1:0];
  endfunction

endpackage

// ===== design/fhc_row_ram.sv =====
// Bucket row memory: one row of WAYS entries per bucket, registered read.
// Depends on fhc_pkg for the row type and depth.
module fhc_row_ram
  import fhc_pkg::*;
(
  input  logic                clk,
  input  logic                rd_en,
  input  logic [BUCKET_W-1:0] rd_addr,
  output fhc_row_t            rd_data,
  input  logic                wr_en,
  input  logic [BUCKET_W-1:0] wr_addr,
  input  fhc_row_t            wr_data
);

  fhc_row_t mem [BUCKETS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/fhc_update.sv =====
// Row update: match and free-way search over one bucket row, new row and result.
// Depends on fhc_pkg for the row, result and status types.
module fhc_update
  import fhc_pkg::*;
(
  input  fhc_row_t    row,
  input  logic        mode,
  input  logic [31:0] address,
  input  logic [15:0] flow_port,
  output fhc_row_t    new_row,
  output fhc_result_t result
);

  logic [WAYS-1:0] match_sel;
  logic [WAYS-1:0] free_sel;
  logic            hit;
  logic            has_free;
  logic [31:0]     sat_count;

  always_comb begin
    match_sel = '0;
    free_sel  = '0;
    hit       = 1'b0;
    has_free  = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if (row[w].valid && !hit && row[w].address == address && row[w].port == flow_port) begin
        hit          = 1'b1;
        match_sel[w] = 1'b1;
      end
      if (!row[w].valid && !has_free) begin
        has_free    = 1'b1;
        free_sel[w] = 1'b1;
      end
    end
  end

  always_comb begin
    new_row   = row;
    sat_count = '0;
    result    = '{hit_count: 32'd0, status: ST_FULL};
    for (int w = 0; w < WAYS; w++) begin
      if (match_sel[w]) begin
        // hold at all ones
        sat_count = (row[w].count == '1) ? row[w].count : row[w].count + 32'd1;
      end
    end
    if (mode == MODE_COUNT) begin
      if (hit) begin
        for (int w = 0; w < WAYS; w++) begin
          if (match_sel[w]) begin
            new_row[w].count = sat_count;
          end
        end
        result = '{hit_count: sat_count, status: ST_COUNTED};
      end else if (has_free) begin
        for (int w = 0; w < WAYS; w++) begin
          if (free_sel[w]) begin
            new_row[w] = '{valid: 1'b1, address: address, port: flow_port, count: 32'd0};
          end
        end
        result = '{hit_count: 32'd0, status: ST_INSERTED};
      end
    end else begin
      if (hit) begin
        for (int w = 0; w < WAYS; w++) begin
          if (match_sel[w]) begin
            new_row[w].valid = 1'b0;
          end
        end
        result = '{hit_count: 32'd0, status: ST_DELETED};
      end else begin
        result = '{hit_count: 32'd0, status: ST_NOT_FOUND};
      end
    end
  end

endmodule

// ===== design/flow_hit_counter_table.sv =====
// Flow hit counter table: flows (address, port) are kept in BUCKETS buckets of
// WAYS ways, picked by the low address byte. A request first reads the bucket
// row from the row memory, then updates it, writes it back and loads the
// result register; a stalled result extends the update step. Rows
// never written since reset read as empty through a per-bucket flag, so the
// block is ready right after reset with no clearing pass.
module flow_hit_counter_table
  import fhc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [31:0] address,
  input  logic [15:0] flow_port,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hit_count,
  output logic [2:0]  status
);

  fhc_state_t          state, state_next;
  logic                accept;
  logic                finish;
  logic                out_free;

  logic                req_mode;
  logic [31:0]         req_address;
  logic [15:0]         req_port;
  logic [BUCKET_W-1:0] req_bucket;
  logic [BUCKET_W-1:0] in_bucket;

  logic [BUCKETS-1:0]  row_init;
  fhc_row_t            ram_q;
  fhc_row_t            cur_row;
  fhc_row_t            new_row;
  fhc_result_t         result;

  assign in_bucket = bucket_of(address[7:0]);
  assign out_free  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_LOOKUP;
      S_LOOKUP: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    finish   = 1'b0;
    unique case (state)
      S_IDLE:   in_ready = 1'b1;
      S_LOOKUP: finish = out_free;
      default:  in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode    <= mode;
      req_address <= address;
      req_port    <= flow_port;
      req_bucket  <= in_bucket;
    end
  end

  // Rows not yet written carry no valid entries.
  always_comb begin
    cur_row = ram_q;
    for (int w = 0; w < WAYS; w++) begin
      if (!row_init[req_bucket]) begin
        cur_row[w].valid = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_init <= '0;
    end else if (finish) begin
      row_init[req_bucket] <= 1'b1;
    end
  end

  fhc_row_ram u_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (in_bucket),
    .rd_data (ram_q),
    .wr_en   (finish),
    .wr_addr (req_bucket),
    .wr_data (new_row)
  );

  fhc_update u_update (
    .row       (cur_row),
    .mode      (req_mode),
    .address   (req_address),
    .flow_port (req_port),
    .new_row   (new_row),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      hit_count <= result.hit_count;
      status    <= result.status;
    end
  end

endmodule

// ===== design/fhc_checker.sv =====
// Port-level checks for the flow hit counter table, bound to the top level.
// Depends on fhc_pkg for the status codes.
module fhc_checker
  import fhc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        mode,
  input logic [31:0] address,
  input logic [15:0] flow_port,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] hit_count,
  input logic [2:0]  status
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit_count) && $stable(status))
    else $error("result word changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_COUNTED || status == ST_INSERTED || status == ST_DELETED ||
                  status == ST_NOT_FOUND || status == ST_FULL)
    else $error("status code out of range");

  a_zero_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_COUNTED |-> hit_count == 32'd0)
    else $error("nonzero count on non-counted result");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken during lookup");

endmodule

bind flow_hit_counter_table fhc_checker u_fhc_checker (.*);
